>>> hw/rtl/load_module_record_parser_macros.svh
// Assertion macros used by the load-module record parser checker.
`ifndef LOAD_MODULE_RECORD_PARSER_MACROS_SVH
`define LOAD_MODULE_RECORD_PARSER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define LMRP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LMRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/lmrp_pkg.sv
// Shared types, constants and helper functions of the load-module record parser.
package lmrp_pkg;

   localparam int MAX_LINE_CHARS = 128;
   localparam int TABLE_DEPTH    = 512;
   localparam int TABLE_AW       = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W        = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_ASTATE = 2'd1;
   localparam logic [1:0] KIND_XFER   = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_SKIPPED  = 3'd1;
   localparam logic [2:0] ST_SYNTAX   = 3'd2;
   localparam logic [2:0] ST_BAD_ALLOC = 3'd3;
   localparam logic [2:0] ST_PAGE_HIGH = 3'd4;
   localparam logic [2:0] ST_XFER_HIGH = 3'd5;
   localparam logic [2:0] ST_UNKNOWN  = 3'd6;

   localparam logic FMT_FIRST  = 1'b0;
   localparam logic FMT_SECOND = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE, OP_WRITE, OP_PAGE, OP_PPA, OP_ASTATE, OP_XFER
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [19:0] addr;
      logic [15:0] data;
      logic [2:0]  status;
      logic        ok;
      logic [15:0] cksum;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] cnt;
      result_type r0;
      result_type r1;
   } push_type;

   // Returns the digit valid flag above the four value bits.
   function automatic logic [4:0] hexval(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
      else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
      else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
      return r;
   endfunction

   function automatic logic [15:0] rotl1(input logic [15:0] v);
      return {v[14:0], v[15]};
   endfunction

endpackage

>>> hw/rtl/lmrp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module lmrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/lmrp_outq.sv
// Small result queue that takes up to two results per cycle and hands out one.
module lmrp_outq (
   input  logic                clock,
   input  logic                reset,
   input  lmrp_pkg::push_type  push,
   input  logic                pop,
   output lmrp_pkg::result_type head,
   output logic                head_valid,
   output logic                has_room
);
   import lmrp_pkg::*;

   result_type           ent_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]    count_ff, count_in;
   logic                 do_pop;

   assign head       = ent_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign has_room   = (count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_AW'(push.cnt);
      rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
      count_in  = count_ff + (QUEUE_AW + 1)'(push.cnt) - (QUEUE_AW + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.cnt != 2'd0) begin
         ent_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.cnt == 2'd2) begin
         ent_ff[wr_ptr_ff + QUEUE_AW'(1)] <= push.r1;
      end
   end
endmodule

>>> hw/rtl/load_module_record_parser.sv
// Top level of the load-module record parser: line decode, page table and result queue.
//
//   Channel  Direction  Handshake           Content
//   req_     in         tvalid/tready       tdata[7:0] character, tlast line end
//   rsp_     out        tvalid/tready       tdata result fields, tlast last of item
//   csr_     in         wr_en               wr_data record format
//
// One item is taken per cycle while not stalled; each item gives zero, one or two results.
// The page table sits in one RAM; the read for a line's first write address
// or for an L record entry is issued a few characters before it is used.
// After reset a clearing pass zeroes all 512 page table entries before
// the first item is taken. Otherwise items stall only when the result queue lacks room.
module load_module_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // kind, target_address, data_word, line_status,
                                    // checksum_ok, computed_checksum, zero fill
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import lmrp_pkg::*;

   logic                fmt_ff;
   logic [7:0]          pos_ff, pos_in, cmd_ff, cmd_in, char5_ff, char5_in;
   logic [19:0]         acc_ff, acc_in, wa_ff, wa_in;
   logic [15:0]         claim_ff, claim_in, run_ff, run_in, xfer_ff, xfer_in;
   logic [3:0]          wc_ff, wc_in, wseen_ff, wseen_in, astate_ff, astate_in;
   logic [3:0]          wok_ff, wok_in, anib_ff, anib_in;
   logic [TABLE_AW-1:0] ti_ff, ti_in, clr_ff;
   logic                halted_ff, halted_in;
   logic [2:0]          fault_ff, fault_in;
   logic [4:0]          nib_ff, nib_in;
   op_type              op_ff, op_in;
   logic start_bad_ff, start_bad_in, claim_bad_ff, claim_bad_in;
   logic count_ok_ff, count_ok_in, rdy_ff, rdy_in, ck_bad_ff, ck_bad_in;
   logic l_stop_ff, l_stop_in, wa_load_ff, wa_load_in, clearing_ff;
   logic [11:0]         lo12_ff, lo12_in;

   logic                ram_we, ram_re;
   logic [TABLE_AW-1:0] ram_wa, ram_ra, ram_wa_mux;
   logic [ENTRY_W-1:0]  ram_wd, ram_rd, ram_wd_mux;

   push_type   push;
   result_type head, e;
   logic       head_valid, has_room, accept;

   logic [4:0]  hx;
   logic [3:0]  hv, q_k;
   logic        h, skip, used, mct, all5, m36, bank, needs, wvalid;
   logic [15:0] code, addr16, w;
   logic [3:0]  hi;
   logic [7:0]  p, c, pm;
   logic [5:0]  k;
   logic [1:0]  q;
   logic [2:0]  st;
   logic        ok;
   logic [15:0] ck;

   assign req_tready = !clearing_ff && has_room;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pos_in = pos_ff; cmd_in = cmd_ff; char5_in = char5_ff; acc_in = acc_ff;
      wa_in = wa_load_ff ? {ram_rd[7:0], lo12_ff} : wa_ff;
      claim_in = claim_ff; run_in = run_ff; xfer_in = xfer_ff; wc_in = wc_ff;
      wseen_in = wseen_ff; astate_in = astate_ff; wok_in = wok_ff; anib_in = anib_ff;
      ti_in = ti_ff; halted_in = halted_ff; fault_in = fault_ff; nib_in = nib_ff;
      op_in = op_ff; start_bad_in = start_bad_ff; claim_bad_in = claim_bad_ff;
      count_ok_in = count_ok_ff; rdy_in = rdy_ff; ck_bad_in = ck_bad_ff;
      l_stop_in = l_stop_ff; lo12_in = lo12_ff; wa_load_in = 1'b0;
      ram_we = 1'b0; ram_wa = ti_ff; ram_wd = '0; ram_re = 1'b0; ram_ra = ti_ff;
      push = '0; e = '0;
      c = req_tdata; p = pos_ff; pm = p - 8'd12;
      hx = hexval(c); hv = hx[3:0]; h = hx[4];
      q = pm[1:0]; k = pm[7:2]; q_k = 4'd0;
      code = 16'd0; used = 1'b1; mct = 1'b0; all5 = 1'b0; m36 = 1'b0; bank = 1'b0;
      addr16 = 16'd0; hi = 4'd0; w = 16'd0; wvalid = 1'b0; skip = 1'b0; needs = 1'b0;
      st = ST_OK; ok = 1'b0; ck = 16'd0;
      if (accept) begin
         if (!halted_ff && p < 8'(MAX_LINE_CHARS)) begin
            if (p == 8'd0) begin
               start_bad_in = (c != "/");
            end else if (p == 8'd1) begin
               cmd_in = c;
            end else if (p <= 8'd6) begin
               acc_in = {acc_ff[15:0], hv};
               if (h) nib_in[3'(p - 8'd2)] = 1'b1;
               if (p == 8'd5) char5_in = c;
            end else if (p == 8'd7) begin
               wc_in = hv; count_ok_in = h;
            end else if (p <= 8'd11) begin
               claim_in = {claim_ff[11:0], hv};
               if (!h) claim_bad_in = 1'b1;
               if (fmt_ff) skip = (cmd_ff == "C") || (cmd_ff == "Z");
               else skip = (cmd_ff == ";") || (cmd_ff == "E") || (cmd_ff == "H")
                           || (cmd_ff == "Z");
               if (p == 8'd11 && !start_bad_ff && !skip && !claim_bad_in) begin
                  rdy_in = 1'b1;
                  addr16 = acc_ff[15:0]; hi = acc_ff[19:16];
                  all5 = (nib_ff == 5'h1F); m36 = (nib_ff[4:1] == 4'hF);
                  bank = (cmd_ff == "O") || (cmd_ff == "Q");
                  if (fmt_ff == FMT_FIRST) begin
                     case (cmd_ff)
                        "M": begin mct = 1'b1; code = 16'h9; end
                        "I", "O": code = 16'h9;
                        "N": code = 16'hA;
                        "L": code = 16'(16'hA + {8'd0, char5_ff} - 16'h30);
                        "Q": code = 16'hB;
                        "A": begin used = 1'b0; code = 16'h6; end
                        "T": begin mct = 1'b1; code = 16'h6; end
                        "Z": begin used = 1'b0; code = 16'h8; end
                        "G", "H": code = 16'h8;
                        "C": begin mct = 1'b1; code = 16'hE; end
                        "B", "P": code = 16'hE;
                        default: ck_bad_in = 1'b1;
                     endcase
                     code = {code[14:0], 1'b0};
                     if (used) begin
                        if (!m36 || !nib_ff[0]) ck_bad_in = 1'b1;
                        code = code ^ addr16;
                        if (mct) code = rotl1(code) ^ {12'd0, hi};
                     end
                     case (cmd_ff)
                        "A": begin op_in = OP_ASTATE; anib_in = 4'hF; end
                        "I", "O": begin
                           if (!all5 || !count_ok_ff) fault_in = ST_SYNTAX;
                           else begin
                              ti_in = {bank, hi, acc_ff[15:12]};
                              ram_re = 1'b1; ram_ra = ti_in;
                              wa_load_in = 1'b1; lo12_in = acc_ff[11:0];
                              op_in = OP_WRITE;
                           end
                        end
                        "L": begin
                           if ((nib_ff & 5'h19) != 5'h19 || !count_ok_ff) fault_in = ST_SYNTAX;
                           else begin
                              ti_in = {acc_ff[4], hi, acc_ff[3:0]}; op_in = OP_PPA;
                           end
                        end
                        "M": begin
                           if (!all5 || !count_ok_ff) fault_in = ST_SYNTAX;
                           else begin wa_in = acc_ff; op_in = OP_WRITE; end
                        end
                        "N", "Q": begin
                           if (!all5) fault_in = ST_SYNTAX;
                           else if (acc_ff > 20'hFF) fault_in = ST_PAGE_HIGH;
                           else if (!count_ok_ff) fault_in = ST_SYNTAX;
                           else begin ti_in = {bank, acc_ff[7:0]}; op_in = OP_PAGE; end
                        end
                        "T": begin
                           if (!all5) fault_in = ST_SYNTAX;
                           else begin
                              xfer_in = addr16; op_in = OP_XFER;
                              if (acc_ff > 20'hFFFF) fault_in = ST_XFER_HIGH;
                           end
                        end
                        default: fault_in = ST_UNKNOWN;
                     endcase
                  end else begin
                     case (cmd_ff)
                        "I": code = 16'd0;
                        "O": code = 16'd1;
                        "E": begin code = 16'd2; used = 1'b0; end
                        "W": begin code = 16'd3; used = 1'b0; end
                        "D": begin code = 16'd4; used = 1'b0; end
                        "P": begin code = 16'd5; used = 1'b0; end
                        "T": code = 16'd6;
                        "C": code = 16'd7;
                        "Z": begin code = 16'd8; used = 1'b0; end
                        default: begin ck_bad_in = 1'b1; used = 1'b0; end
                     endcase
                     if (used) begin
                        if (!m36) ck_bad_in = 1'b1;
                        code = {code[14:0], 1'b0} ^ addr16;
                     end
                     case (cmd_ff)
                        "D", "P", "E", "W": op_in = op_ff;
                        "I", "O": begin
                           if (!m36 || !count_ok_ff) fault_in = ST_SYNTAX;
                           else begin
                              ti_in = {bank, astate_ff, acc_ff[15:12]};
                              ram_re = 1'b1; ram_ra = ti_in;
                              wa_load_in = 1'b1; lo12_in = acc_ff[11:0];
                              op_in = OP_WRITE;
                           end
                        end
                        "T": begin
                           if (!m36) fault_in = ST_SYNTAX;
                           else begin xfer_in = addr16; op_in = OP_XFER; end
                        end
                        default: fault_in = ST_UNKNOWN;
                     endcase
                  end
                  if (!count_ok_ff) ck_bad_in = 1'b1;
                  run_in = code;
               end
            end else if (rdy_ff) begin
               if (q == 2'd0) begin
                  acc_in = {16'd0, hv}; wok_in = {3'd0, h};
                  if (op_ff == OP_PPA) ram_re = 1'b1;
               end else begin
                  acc_in = {acc_ff[15:0], hv};
                  if (h) wok_in[q] = 1'b1;
               end
               if (q == 2'd3) begin
                  w = acc_in[15:0]; wvalid = (wok_in == 4'hF);
                  if (k == 6'd0 && op_ff == OP_ASTATE) anib_in = wvalid ? w[3:0] : 4'hF;
                  if (k < {2'd0, wc_ff}) begin
                     q_k = k[3:0];
                     wseen_in = q_k + 4'd1;
                     if (!ck_bad_ff) begin
                        if (wvalid) run_in = rotl1(run_ff) ^ w;
                        else ck_bad_in = 1'b1;
                     end
                     if (fault_ff == ST_OK) begin
                        if (op_ff == OP_WRITE) begin
                           if (!wvalid) fault_in = ST_SYNTAX;
                           else begin
                              e.kind = KIND_WRITE; e.addr = wa_in; e.data = w;
                              push.r0 = e; push.cnt = 2'd1;
                              wa_in = wa_in + 20'd1;
                           end
                        end else if (op_ff == OP_PAGE) begin
                           if (!wvalid) fault_in = ST_SYNTAX;
                           else begin
                              ram_we = 1'b1; ram_wa = ti_ff; ram_wd = w;
                              ti_in = {ti_ff[8], ti_ff[7:0] + 8'd1};
                           end
                        end else if (op_ff == OP_PPA && !l_stop_ff) begin
                           if (!wok_in[0]) fault_in = ST_SYNTAX;
                           else if (w[15:12] != 4'd2) fault_in = ST_BAD_ALLOC;
                           else if (wok_in[3:1] != 3'h7 || w[11:0] > 12'hFF)
                              fault_in = ST_SYNTAX;
                           else begin
                              ram_we = 1'b1; ram_wa = ti_ff;
                              ram_wd = {ram_rd[15:8], w[7:0]};
                              if (ti_ff[3:0] == 4'hF) l_stop_in = 1'b1;
                              else ti_in = ti_ff + TABLE_AW'(1);
                           end
                        end
                     end
                  end
               end
            end
         end
         if (pos_ff != 8'hFF) pos_in = pos_ff + 8'd1;
         if (req_tlast) begin
            if (fmt_ff) skip = (cmd_in == "C") || (cmd_in == "Z");
            else skip = (cmd_in == ";") || (cmd_in == "E") || (cmd_in == "H")
                        || (cmd_in == "Z");
            if (halted_ff || p == 8'd0) st = ST_SKIPPED;
            else if (start_bad_in) st = ST_SYNTAX;
            else if (skip) st = ST_SKIPPED;
            else if (!rdy_in) st = ST_SYNTAX;
            else begin
               needs = (op_in == OP_WRITE) || (op_in == OP_PAGE)
                       || (op_in == OP_PPA && !l_stop_in);
               if (wseen_in < wc_in) begin
                  ck_bad_in = 1'b1;
                  if (fault_in == ST_OK && needs) fault_in = ST_SYNTAX;
               end
               st = fault_in;
               e = '0;
               if (op_in == OP_ASTATE && fault_in == ST_OK) begin
                  astate_in = anib_in;
                  e.kind = KIND_ASTATE; e.data = {12'd0, anib_in}; e.status = st;
               end
               if (op_in == OP_XFER) begin
                  e.kind = KIND_XFER; e.addr = {4'd0, xfer_in}; e.status = st;
               end
               if ((op_in == OP_ASTATE && fault_in == ST_OK) || op_in == OP_XFER) begin
                  if (push.cnt == 2'd0) push.r0 = e; else push.r1 = e;
                  push.cnt = push.cnt + 2'd1;
               end
               if (!ck_bad_in) begin ck = run_in; ok = (run_in == claim_in); end
            end
            if (st >= ST_SYNTAX && st <= ST_XFER_HIGH) halted_in = 1'b1;
            e = '0;
            e.kind = KIND_DONE; e.status = st; e.ok = ok; e.cksum = ck;
            if (push.cnt == 2'd0) push.r0 = e; else push.r1 = e;
            push.cnt = push.cnt + 2'd1;
            pos_in = 8'd0; cmd_in = 8'd0; acc_in = 20'd0; claim_in = 16'd0;
            run_in = 16'd0; wc_in = 4'd0; wseen_in = 4'd0; fault_in = ST_OK;
            nib_in = 5'd0; wok_in = 4'd0; char5_in = 8'd0; op_in = OP_NONE;
            anib_in = 4'hF; start_bad_in = 1'b0; claim_bad_in = 1'b0;
            count_ok_in = 1'b0; rdy_in = 1'b0; ck_bad_in = 1'b0; l_stop_in = 1'b0;
            xfer_in = 16'd0;
         end
         if (push.cnt == 2'd1) push.r0.last = 1'b1;
         if (push.cnt == 2'd2) push.r1.last = 1'b1;
      end
   end

   assign ram_wa_mux = clearing_ff ? clr_ff : ram_wa;
   assign ram_wd_mux = clearing_ff ? '0 : ram_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_FIRST; pos_ff <= '0; cmd_ff <= '0; char5_ff <= '0; acc_ff <= '0;
         wa_ff <= '0; claim_ff <= '0; run_ff <= '0; xfer_ff <= '0; wc_ff <= '0;
         wseen_ff <= '0; astate_ff <= '0; wok_ff <= '0; anib_ff <= 4'hF; ti_ff <= '0;
         halted_ff <= 1'b0; fault_ff <= ST_OK; nib_ff <= '0; op_ff <= OP_NONE;
         start_bad_ff <= 1'b0; claim_bad_ff <= 1'b0; count_ok_ff <= 1'b0;
         rdy_ff <= 1'b0; ck_bad_ff <= 1'b0; l_stop_ff <= 1'b0; lo12_ff <= '0;
         wa_load_ff <= 1'b0; clearing_ff <= 1'b1; clr_ff <= '0;
      end else begin
         if (csr_wr_en) fmt_ff <= csr_wr_data;
         pos_ff <= pos_in; cmd_ff <= cmd_in; char5_ff <= char5_in; acc_ff <= acc_in;
         wa_ff <= wa_in; claim_ff <= claim_in; run_ff <= run_in; xfer_ff <= xfer_in;
         wc_ff <= wc_in; wseen_ff <= wseen_in; astate_ff <= astate_in;
         wok_ff <= wok_in; anib_ff <= anib_in; ti_ff <= ti_in; halted_ff <= halted_in;
         fault_ff <= fault_in; nib_ff <= nib_in; op_ff <= op_in;
         start_bad_ff <= start_bad_in; claim_bad_ff <= claim_bad_in;
         count_ok_ff <= count_ok_in; rdy_ff <= rdy_in; ck_bad_ff <= ck_bad_in;
         l_stop_ff <= l_stop_in; lo12_ff <= lo12_in; wa_load_ff <= wa_load_in;
         if (clearing_ff) begin
            if (&clr_ff) clearing_ff <= 1'b0;
            clr_ff <= clr_ff + TABLE_AW'(1);
         end
      end
   end

   lmrp_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock  (clock),
      .wr_en  (ram_we || clearing_ff),
      .wr_addr(ram_wa_mux),
      .wr_data(ram_wd_mux),
      .rd_en  (ram_re),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   lmrp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .head      (head),
      .head_valid(head_valid),
      .has_room  (has_room)
   );

   assign rsp_tvalid = head_valid;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {6'd0, head.cksum, head.ok, head.status, head.data, head.addr,
                        head.kind};
endmodule

>>> hw/rtl/lmrp_checker.sv
// Port-level checker of the load-module record parser, bound to the top level.
`include "load_module_record_parser_macros.svh"

module lmrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);
   `LMRP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")
   `LMRP_ASSERT_NOW(a_clear_stall, clock, reset, $past(reset), !req_tready && !rsp_tvalid, "items moved during the table clearing pass")
   `LMRP_ASSERT_NOW(a_write_clean, clock, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd0, rsp_tdata[57:38] == 20'd0, "write item carries status or checksum")
   `LMRP_ASSERT_NOW(a_done_last, clock, reset, rsp_tvalid && rsp_tdata[1:0] == 2'd3, rsp_tlast && rsp_tdata[37:2] == 36'd0, "line done item malformed")
endmodule

bind load_module_record_parser lmrp_checker u_lmrp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
